>>> rtl/gpc_pkg.sv
package gpc_pkg;

  // Storage is laid out for the widest configuration: eight ports of eight pins.
  localparam int unsigned PORT_SLOTS = 8;
  localparam int unsigned PIN_SLOTS  = 8;
  localparam int unsigned IRQ_WIDTH  = 6;
  // Pad registers kept in RAM, one row of this many entries per port.
  localparam int unsigned PAD_ROW    = 8;
  localparam logic [31:0] BYTE_MASK  = 32'h0000_00FF;
  localparam logic [3:0]  NIBBLE_MASK = 4'hF;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2
  } req_code_t;

  typedef enum logic [4:0] {
    REG_DATA   = 5'd0,
    REG_DIR    = 5'd1,
    REG_IS     = 5'd2,
    REG_IBE    = 5'd3,
    REG_IEV    = 5'd4,
    REG_IM     = 5'd5,
    REG_RIS    = 5'd6,
    REG_MIS    = 5'd7,
    REG_ICR    = 5'd8,
    REG_AFSEL  = 5'd9,
    REG_DEN    = 5'd10,
    REG_AMSEL  = 5'd11,
    REG_PUR    = 5'd12,
    REG_PDR    = 5'd13,
    REG_ODR    = 5'd14,
    REG_DRIVE2 = 5'd15,
    REG_DRIVE4 = 5'd16,
    REG_DRIVE8 = 5'd17,
    REG_PCTL   = 5'd18
  } reg_code_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  port_sel;
    logic [4:0]  reg_sel;
    logic [7:0]  addr_mask;
    logic [31:0] write_data;
    logic [7:0]  pin_levels;
  } req_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [7:0]  pin_drive;
    logic [7:0]  pin_enable;
    logic [5:0]  irq_lines;
  } rsp_item_t;

endpackage

>>> rtl/gpc_ram.sv
module gpc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/gpio_port_controller.sv
// Channel  | Valid      | Stall      | Payload
// request  | req_valid  | req_stall  | req (req_item_t): tick, register read or write
// response | rsp_valid  | rsp_stall  | rsp (rsp_item_t): one per request item
//
// When an item is accepted, the port state and the middle-stage result are updated
// at the accepting edge, the pad RAM read is registered, and the response register
// follows. One item is accepted every cycle while req_stall is low.
// Reset clears all port state and the pad RAM valid bits at once; no sweep.
// A stalled response holds; one more item may enter the middle stage behind it.
module gpio_port_controller
  import gpc_pkg::*;
#(
  parameter int unsigned NUM_PORTS = 6,
  parameter int unsigned PINS      = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  localparam logic [7:0]  PIN_MASK  = 8'((1 << PINS) - 1);
  localparam logic [31:0] FUNC_FIELD_MASK = 32'((64'd1 << (4 * PINS)) - 64'd1);
  localparam int unsigned RAM_DEPTH = NUM_PORTS * PAD_ROW;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

  logic [7:0]  out_bits       [NUM_PORTS];
  logic [7:0]  dir_bits       [NUM_PORTS];
  logic [7:0]  sense_bits     [NUM_PORTS];
  logic [7:0]  both_edge_bits [NUM_PORTS];
  logic [7:0]  event_bits     [NUM_PORTS];
  logic [7:0]  irq_mask_bits  [NUM_PORTS];
  logic [7:0]  raw_status     [NUM_PORTS];
  logic [7:0]  last_levels    [NUM_PORTS];
  logic [7:0]  afsel_bits     [NUM_PORTS];
  logic [7:0]  den_bits       [NUM_PORTS];
  logic [31:0] pin_function   [NUM_PORTS];

  logic [7:0]  out_bits_next       [NUM_PORTS];
  logic [7:0]  dir_bits_next       [NUM_PORTS];
  logic [7:0]  sense_bits_next     [NUM_PORTS];
  logic [7:0]  both_edge_bits_next [NUM_PORTS];
  logic [7:0]  event_bits_next     [NUM_PORTS];
  logic [7:0]  irq_mask_bits_next  [NUM_PORTS];
  logic [7:0]  raw_status_next     [NUM_PORTS];
  logic [7:0]  last_levels_next    [NUM_PORTS];
  logic [7:0]  afsel_bits_next     [NUM_PORTS];
  logic [7:0]  den_bits_next       [NUM_PORTS];
  logic [31:0] pin_function_next   [NUM_PORTS];

  logic                  accept;
  logic                  stage_adv;
  logic                  port_ok;
  logic                  is_tick;
  logic                  is_read;
  logic                  is_write;
  logic                  is_pad_ram;
  logic [7:0]            w8;
  logic [PORT_SLOTS-1:0] irq_any;
  logic [7:0]            a_out;
  logic [7:0]            a_dir;
  logic [7:0]            a_last;
  logic [7:0]            a_stat;
  logic [7:0]            a_im;
  logic [7:0]            a_afsel;
  logic [7:0]            a_den;
  logic [7:0]            a_sense;
  logic [7:0]            a_ibe;
  logic [7:0]            a_iev;
  logic [31:0]           a_pctl;
  logic [31:0]           rd_comb;
  rsp_item_t             stage_rsp_next;

  logic [2:0]            pad_idx;
  logic [RAM_AW-1:0]     ram_addr;
  logic                  ram_we;
  logic [7:0]            ram_rdata;
  logic [RAM_DEPTH-1:0]  ram_vld;

  logic                  stage_valid;
  rsp_item_t             stage_rsp;
  logic                  stage_from_ram;
  logic                  stage_ram_vld;

  assign stage_adv = !rsp_valid || !rsp_stall;
  assign req_stall = stage_valid && !stage_adv;
  assign accept    = req_valid && !req_stall;

  assign port_ok    = {1'b0, req.port_sel} < 4'(NUM_PORTS);
  assign is_tick    = port_ok && (req.req_type == REQ_TICK);
  assign is_read    = port_ok && (req.req_type == REQ_READ);
  assign is_write   = port_ok && (req.req_type == REQ_WRITE);
  assign is_pad_ram = (req.reg_sel >= REG_AMSEL) && (req.reg_sel <= REG_DRIVE8);
  assign w8         = req.write_data[7:0] & PIN_MASK;

  assign pad_idx  = 3'(req.reg_sel - REG_AMSEL);
  assign ram_addr = RAM_AW'({req.port_sel, pad_idx});
  assign ram_we   = accept && is_write && is_pad_ram;

  gpc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_pad_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (w8),
    .re    (accept),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // Next state of every port, the interrupt summary after the step, and the
  // addressed port's values after the step.
  always_comb begin : port_next
    logic       hit;
    logic [7:0] now_lv;
    logic [7:0] rise;
    logic [7:0] fall;
    logic [7:0] edges;
    logic [7:0] lvl;
    logic [7:0] stat;
    irq_any = '0;
    a_out   = '0;
    a_dir   = '0;
    a_last  = '0;
    a_stat  = '0;
    a_im    = '0;
    a_afsel = '0;
    a_den   = '0;
    a_sense = '0;
    a_ibe   = '0;
    a_iev   = '0;
    a_pctl  = '0;
    for (int q = 0; q < NUM_PORTS; q++) begin
      hit = accept && (req.port_sel == 3'(q));
      out_bits_next[q]       = out_bits[q];
      dir_bits_next[q]       = dir_bits[q];
      sense_bits_next[q]     = sense_bits[q];
      both_edge_bits_next[q] = both_edge_bits[q];
      event_bits_next[q]     = event_bits[q];
      irq_mask_bits_next[q]  = irq_mask_bits[q];
      raw_status_next[q]     = raw_status[q];
      last_levels_next[q]    = last_levels[q];
      afsel_bits_next[q]     = afsel_bits[q];
      den_bits_next[q]       = den_bits[q];
      pin_function_next[q]   = pin_function[q];

      now_lv = req.pin_levels & PIN_MASK;
      rise   = now_lv & ~last_levels[q];
      fall   = ~now_lv & last_levels[q];
      edges  = (both_edge_bits[q] & (rise | fall)) |
               (~both_edge_bits[q] & event_bits[q] & rise) |
               (~both_edge_bits[q] & ~event_bits[q] & fall);

      if (hit && is_tick) begin
        raw_status_next[q]  = (raw_status[q] | edges) & ~sense_bits[q] & PIN_MASK;
        last_levels_next[q] = now_lv;
      end else if (hit && is_write) begin
        case (req.reg_sel)
          REG_DATA: begin
            out_bits_next[q] = (out_bits[q] & ~(req.addr_mask & PIN_MASK)) |
                               (req.write_data[7:0] & req.addr_mask & PIN_MASK);
          end
          REG_DIR:   dir_bits_next[q] = w8;
          REG_IS: begin
            sense_bits_next[q] = w8;
            raw_status_next[q] = raw_status[q] & ~w8;
          end
          REG_IBE:   both_edge_bits_next[q] = w8;
          REG_IEV:   event_bits_next[q]     = w8;
          REG_IM:    irq_mask_bits_next[q]  = w8;
          REG_ICR:   raw_status_next[q]     = raw_status[q] & ~w8;
          REG_AFSEL: afsel_bits_next[q]     = w8;
          REG_DEN:   den_bits_next[q]       = w8;
          REG_PCTL:  pin_function_next[q]   = req.write_data & FUNC_FIELD_MASK;
          default: begin
          end
        endcase
      end

      // Level-mode pins report the live comparison, edge-mode pins the latch.
      lvl  = (event_bits_next[q] & last_levels_next[q]) |
             (~event_bits_next[q] & ~last_levels_next[q]);
      stat = ((raw_status_next[q] & ~sense_bits_next[q]) |
              (sense_bits_next[q] & lvl)) & PIN_MASK;
      irq_any[q] = |(stat & irq_mask_bits_next[q]);

      if (req.port_sel == 3'(q)) begin
        a_out   = out_bits_next[q];
        a_dir   = dir_bits_next[q];
        a_last  = last_levels_next[q];
        a_stat  = stat;
        a_im    = irq_mask_bits_next[q];
        a_afsel = afsel_bits_next[q];
        a_den   = den_bits_next[q];
        a_sense = sense_bits_next[q];
        a_ibe   = both_edge_bits_next[q];
        a_iev   = event_bits_next[q];
        a_pctl  = pin_function_next[q];
      end
    end
  end

  always_comb begin
    rd_comb = '0;
    if (is_read) begin
      case (req.reg_sel)
        REG_DATA: begin
          rd_comb = 32'(((a_out & a_dir) | (a_last & ~a_dir)) & req.addr_mask & PIN_MASK);
        end
        REG_DIR:   rd_comb = 32'(a_dir);
        REG_IS:    rd_comb = 32'(a_sense);
        REG_IBE:   rd_comb = 32'(a_ibe);
        REG_IEV:   rd_comb = 32'(a_iev);
        REG_IM:    rd_comb = 32'(a_im);
        REG_RIS:   rd_comb = 32'(a_stat);
        REG_MIS:   rd_comb = 32'(a_stat & a_im);
        REG_AFSEL: rd_comb = 32'(a_afsel);
        REG_DEN:   rd_comb = 32'(a_den);
        REG_PCTL:  rd_comb = a_pctl;
        default:   rd_comb = '0;
      endcase
    end
  end

  always_comb begin
    stage_rsp_next.read_data  = rd_comb;
    stage_rsp_next.pin_drive  = port_ok ? (a_out & PIN_MASK) : 8'd0;
    stage_rsp_next.pin_enable = port_ok ? (a_dir & a_den & ~a_afsel & PIN_MASK) : 8'd0;
    stage_rsp_next.irq_lines  = irq_any[IRQ_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < NUM_PORTS; q++) begin
        out_bits[q]       <= '0;
        dir_bits[q]       <= '0;
        sense_bits[q]     <= '0;
        both_edge_bits[q] <= '0;
        event_bits[q]     <= '0;
        irq_mask_bits[q]  <= '0;
        raw_status[q]     <= '0;
        last_levels[q]    <= '0;
        afsel_bits[q]     <= '0;
        den_bits[q]       <= '0;
        pin_function[q]   <= '0;
      end
      ram_vld <= '0;
    end else begin
      out_bits       <= out_bits_next;
      dir_bits       <= dir_bits_next;
      sense_bits     <= sense_bits_next;
      both_edge_bits <= both_edge_bits_next;
      event_bits     <= event_bits_next;
      irq_mask_bits  <= irq_mask_bits_next;
      raw_status     <= raw_status_next;
      last_levels    <= last_levels_next;
      afsel_bits     <= afsel_bits_next;
      den_bits       <= den_bits_next;
      pin_function   <= pin_function_next;
      if (ram_we) begin
        ram_vld[ram_addr] <= 1'b1;
      end
    end
  end

  // Middle stage: waits for the registered pad RAM read.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!req_stall) begin
      stage_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_rsp      <= stage_rsp_next;
      stage_from_ram <= is_read && is_pad_ram;
      stage_ram_vld  <= ram_vld[ram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stage_adv) begin
      rsp_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && stage_valid) begin
      rsp.read_data  <= stage_from_ram ? (stage_ram_vld ? 32'(ram_rdata) : 32'd0)
                                       : stage_rsp.read_data;
      rsp.pin_drive  <= stage_rsp.pin_drive;
      rsp.pin_enable <= stage_rsp.pin_enable;
      rsp.irq_lines  <= stage_rsp.irq_lines;
    end
  end

endmodule

>>> rtl/gpc_checker.sv
module gpc_checker
  import gpc_pkg::*;
#(
  parameter int unsigned NUM_PORTS = 6
) (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_stall,
  input req_item_t req,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_item_t rsp
);

  logic req_acc;

  assign req_acc = req_valid && !req_stall;

  // A held response must not move.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // Requests only back up behind a stalled response.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("request stalled with no response waiting");

  // Ticks and writes read zero when the response path is free.
  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    (req_acc && (req.req_type != REQ_READ) && !rsp_stall) ##1 !rsp_stall
    |=> rsp_valid && (rsp.read_data == 32'd0))
    else $error("non-read item returned data");

  // An absent port gives an all-zero port view.
  a_absent_port: assert property (@(posedge clk) disable iff (rst)
    (req_acc && ({1'b0, req.port_sel} >= 4'(NUM_PORTS)) && !rsp_stall) ##1 !rsp_stall
    |=> rsp_valid && (rsp.read_data == 32'd0) && (rsp.pin_drive == 8'd0) &&
        (rsp.pin_enable == 8'd0))
    else $error("absent port produced nonzero fields");

  // Interrupt lines only exist for implemented ports.
  a_irq_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((14'(rsp.irq_lines) >> NUM_PORTS) == 14'd0))
    else $error("interrupt line set for an absent port");

endmodule

bind gpio_port_controller gpc_checker #(.NUM_PORTS(NUM_PORTS)) u_gpc_checker (.*);
